FILE: sv/stfw_pkg.sv
// Shared types and constants for the semaphore table with FIFO wait queues.
// Holds request modes, field widths, shared-unit opcodes and control structs.
// No dependencies.
package stfw_pkg;

  localparam int MODE_W = 2;
  localparam int PROC_W = 4;
  localparam int SEM_W  = 5;
  localparam int CNT_W  = 16;
  localparam int IDX_W  = 5;

  localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WAIT   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SIGNAL = 2'd2;

  localparam logic [CNT_W-1:0] COUNT_MAX = 16'h7FFF;
  localparam logic [CNT_W-1:0] COUNT_MIN = 16'h8000;

  typedef logic [1:0] alu_op_t;
  localparam alu_op_t ALU_DEC_SAT  = 2'd0;
  localparam alu_op_t ALU_INC_SAT  = 2'd1;
  localparam alu_op_t ALU_INC_WRAP = 2'd2;

  typedef struct packed {
    alu_op_t          op;
    logic [CNT_W-1:0] operand;
    logic [CNT_W-1:0] limit;
  } alu_req_t;

  typedef struct packed {
    logic rd_en;
    logic cnt_we;
    logic meta_we;
    logic wst_we;
    logic wst_re;
  } tbl_ctrl_t;

endpackage

FILE: sv/semaphore_table_fifo_wait.sv
// Semaphore table top level: request sequencer, result register and the
// instances of the shared unit and the storage. Depends on stfw_pkg,
// stfw_alu and stfw_table.
//
// A table of NUM_SEMS counting semaphores, each with a circular FIFO of up
// to NUM_PROCS waiting process ids. Allocate hands out the lowest free entry;
// since entries are never freed this is tracked by a fill count, and the
// table is full once NUM_SEMS entries are handed out (alloc_failed). Wait
// decrements the 16-bit saturating count and, if it went negative and the
// queue has room, queues proc_id and raises block_caller. Signal increments
// the count and, if a waiter is queued, dequeues the oldest one onto
// wake_proc with wake_valid. Unused modes and wait/signal on an out-of-range
// sem_id produce an all-zero result transaction. Every request yields
// exactly one result. Timing: one request at a time. A request runs read
// (registered memory read), count update, pointer update (wait/signal that
// touch the queue only) and result load, each its own sequencer state, and
// in_ready returns as the result register loads; no new request is taken
// before then. The pace is set by the read-modify-write of the semaphore
// entry through registered memory reads and the single inc/dec unit, used
// once for the count and once for the queue pointer. The result register
// holds a finished transaction while the next request is accepted; a new
// result waits in the sequencer only while the previous one has not been
// taken.
module semaphore_table_fifo_wait import stfw_pkg::*; #(
  parameter int NUM_SEMS  = 32,
  parameter int NUM_PROCS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [MODE_W-1:0]       in_mode,
  input  logic [PROC_W-1:0]       in_proc_id,
  input  logic [SEM_W-1:0]        in_sem_id,
  input  logic signed [CNT_W-1:0] in_init_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [IDX_W-1:0]        out_alloc_index,
  output logic                    out_alloc_failed,
  output logic                    out_block_caller,
  output logic                    out_wake_valid,
  output logic [PROC_W-1:0]       out_wake_proc
);

  localparam int SEM_IW = $clog2(NUM_SEMS);
  localparam int PTR_W  = $clog2(NUM_PROCS);
  localparam int WC_W   = $clog2(NUM_PROCS + 1);
  localparam int AC_W   = $clog2(NUM_SEMS + 1);
  localparam int META_W = WC_W + 2 * PTR_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_CNT  = 3'd2;
  localparam logic [2:0] S_PTR  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [MODE_W-1:0] mode_r;
  logic [PROC_W-1:0] proc_r;
  logic [SEM_IW-1:0] sem_r;
  logic [CNT_W-1:0]  init_r;
  logic              sem_ok_r;
  logic [AC_W-1:0]   alloc_cnt_r;
  logic              enq_r, deq_r;
  logic              enq_nxt, deq_nxt;

  logic [IDX_W-1:0]  res_idx_r;
  logic              res_fail_r, res_block_r, res_wake_r;

  logic              out_valid_r;
  logic [IDX_W-1:0]  out_idx_r;
  logic              out_fail_r, out_block_r, out_wake_r;
  logic [PROC_W-1:0] out_proc_r;

  tbl_ctrl_t         ctrl;
  alu_req_t          alu_req;
  logic [CNT_W-1:0]  alu_res;
  logic [SEM_IW-1:0] cnt_waddr;
  logic [CNT_W-1:0]  cnt_wdata;
  logic [META_W-1:0] meta_wdata;
  logic [SEM_IW+PTR_W-1:0] wst_addr;
  logic [CNT_W-1:0]  cnt_rd;
  logic [META_W-1:0] meta_rd;
  logic [PROC_W-1:0] wst_rd;

  logic [WC_W-1:0]   m_wcnt, wcnt_new;
  logic [PTR_W-1:0]  m_head, m_tail, head_new, tail_new, ptr_adv;
  logic              in_acc, out_free, qop, alloc_ok;

  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);

  assign m_wcnt = meta_rd[META_W-1 -: WC_W];
  assign m_head = meta_rd[2*PTR_W-1 -: PTR_W];
  assign m_tail = meta_rd[PTR_W-1:0];

  assign ptr_adv  = PTR_W'(alu_res);
  assign alloc_ok = (alloc_cnt_r != AC_W'(NUM_SEMS));

  always_comb begin
    qop = 1'b0;
    if (mode_r inside {MODE_WAIT, MODE_SIGNAL}) begin
      qop = sem_ok_r;
    end
  end

  // shared unit: count update in S_CNT, pointer advance in S_PTR
  always_comb begin
    alu_req.limit = CNT_W'(NUM_PROCS - 1);
    if (state_r == S_PTR) begin
      alu_req.op      = ALU_INC_WRAP;
      alu_req.operand = CNT_W'(enq_r ? m_tail : m_head);
    end else begin
      alu_req.op      = (mode_r == MODE_WAIT) ? ALU_DEC_SAT : ALU_INC_SAT;
      alu_req.operand = cnt_rd;
    end
  end

  stfw_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  // queue decisions taken on the updated count
  assign enq_nxt = qop && (mode_r == MODE_WAIT) && alu_res[CNT_W-1]
                   && (m_wcnt != WC_W'(NUM_PROCS));
  assign deq_nxt = qop && (mode_r == MODE_SIGNAL) && (m_wcnt != '0);

  // new queue metadata for the pointer step
  always_comb begin
    if (enq_r) begin
      wcnt_new = m_wcnt + WC_W'(1);
      head_new = (m_wcnt == '0) ? '0 : m_head;
      tail_new = (m_wcnt == '0) ? '0 : ptr_adv;
    end else begin
      wcnt_new = m_wcnt - WC_W'(1);
      head_new = (wcnt_new != '0) ? ptr_adv : m_head;
      tail_new = m_tail;
    end
  end

  assign meta_wdata = {wcnt_new, head_new, tail_new};
  assign cnt_waddr  = (mode_r == MODE_ALLOC) ? SEM_IW'(alloc_cnt_r) : sem_r;
  assign cnt_wdata  = (mode_r == MODE_ALLOC) ? init_r : alu_res;
  assign wst_addr   = {sem_r, (state_r == S_PTR) ? tail_new : m_head};

  // sequencer
  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_READ;
      end
      S_READ: begin
        ctrl.rd_en = qop;
        state_nxt  = S_CNT;
      end
      S_CNT: begin
        ctrl.cnt_we = qop || ((mode_r == MODE_ALLOC) && alloc_ok);
        ctrl.wst_re = deq_nxt;
        state_nxt   = (enq_nxt || deq_nxt) ? S_PTR : S_DONE;
      end
      S_PTR: begin
        ctrl.meta_we = 1'b1;
        ctrl.wst_we  = enq_r;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  stfw_table #(
    .NUM_SEMS  (NUM_SEMS),
    .NUM_PROCS (NUM_PROCS)
  ) u_table (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .sem_addr   (sem_r),
    .cnt_waddr  (cnt_waddr),
    .cnt_wdata  (cnt_wdata),
    .meta_wdata (meta_wdata),
    .wst_addr   (wst_addr),
    .wst_wdata  (proc_r),
    .cnt_rd     (cnt_rd),
    .meta_rd    (meta_rd),
    .wst_rd     (wst_rd)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      alloc_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // advance the fill count on a successful allocate
      if (state_r == S_CNT && mode_r == MODE_ALLOC && alloc_ok) begin
        alloc_cnt_r <= alloc_cnt_r + AC_W'(1);
      end
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (state_r == S_DONE && out_free) out_valid_r <= 1'b1;
    end
  end

  // request fields, working results and the output register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r      <= in_mode;
      proc_r      <= in_proc_id;
      sem_r       <= SEM_IW'(in_sem_id);
      init_r      <= in_init_value;
      sem_ok_r    <= (32'(in_sem_id) < NUM_SEMS);
      res_idx_r   <= '0;
      res_fail_r  <= 1'b0;
      res_block_r <= 1'b0;
      res_wake_r  <= 1'b0;
    end
    if (state_r == S_CNT) begin
      enq_r <= enq_nxt;
      deq_r <= deq_nxt;
      if (mode_r == MODE_ALLOC) begin
        res_idx_r  <= alloc_ok ? IDX_W'(alloc_cnt_r) : '0;
        res_fail_r <= !alloc_ok;
      end
    end
    if (state_r == S_PTR) begin
      res_block_r <= enq_r;
      res_wake_r  <= deq_r;
    end
    // load the finished transaction once the output register is free
    if (state_r == S_DONE && out_free) begin
      out_idx_r   <= res_idx_r;
      out_fail_r  <= res_fail_r;
      out_block_r <= res_block_r;
      out_wake_r  <= res_wake_r;
      out_proc_r  <= res_wake_r ? wst_rd : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_alloc_index  = out_idx_r;
  assign out_alloc_failed = out_fail_r;
  assign out_block_caller = out_block_r;
  assign out_wake_valid   = out_wake_r;
  assign out_wake_proc    = out_proc_r;

endmodule

FILE: sv/stfw_alu.sv
// Shared increment/decrement unit: saturating count update and wrapping
// queue pointer advance. Depends on stfw_pkg.
module stfw_alu import stfw_pkg::*; (
  input  alu_req_t         req,
  output logic [CNT_W-1:0] res
);

  logic [CNT_W-1:0] sum;

  // one adder: add all-ones to decrement, one to increment
  assign sum = req.operand + ((req.op == ALU_DEC_SAT) ? {CNT_W{1'b1}} : CNT_W'(1));

  always_comb begin
    case (req.op)
      ALU_DEC_SAT:  res = (req.operand == COUNT_MIN) ? req.operand : sum;
      ALU_INC_SAT:  res = (req.operand == COUNT_MAX) ? req.operand : sum;
      ALU_INC_WRAP: res = (req.operand >= req.limit) ? '0 : sum;
      default:      res = req.operand;
    endcase
  end

endmodule

FILE: sv/stfw_table.sv
// Semaphore storage: count memory, queue metadata memory with per-entry
// valid bits, and the waiter store. Depends on stfw_pkg.
module stfw_table import stfw_pkg::*; #(
  parameter  int NUM_SEMS  = 32,
  parameter  int NUM_PROCS = 16,
  localparam int SEM_IW    = $clog2(NUM_SEMS),
  localparam int PTR_W     = $clog2(NUM_PROCS),
  localparam int WC_W      = $clog2(NUM_PROCS + 1),
  localparam int META_W    = WC_W + 2 * PTR_W
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  tbl_ctrl_t               ctrl,
  input  logic [SEM_IW-1:0]       sem_addr,
  input  logic [SEM_IW-1:0]       cnt_waddr,
  input  logic [CNT_W-1:0]        cnt_wdata,
  input  logic [META_W-1:0]       meta_wdata,
  input  logic [SEM_IW+PTR_W-1:0] wst_addr,
  input  logic [PROC_W-1:0]       wst_wdata,
  output logic [CNT_W-1:0]        cnt_rd,
  output logic [META_W-1:0]       meta_rd,
  output logic [PROC_W-1:0]       wst_rd
);

  localparam int WST_DEPTH = NUM_SEMS << PTR_W;

  logic [CNT_W-1:0]  cnt_mem  [NUM_SEMS];
  logic [META_W-1:0] meta_mem [NUM_SEMS];
  logic [PROC_W-1:0] wst_mem  [WST_DEPTH];

  logic [NUM_SEMS-1:0] meta_vld_r;
  logic                rd_vld_r;
  logic [CNT_W-1:0]    cnt_rd_r;
  logic [META_W-1:0]   meta_q_r;
  logic [PROC_W-1:0]   wst_rd_r;

  always_ff @(posedge clk) begin
    if (ctrl.cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (ctrl.meta_we) begin
      meta_mem[sem_addr] <= meta_wdata;
    end
    if (ctrl.rd_en) begin
      cnt_rd_r <= cnt_mem[sem_addr];
      meta_q_r <= meta_mem[sem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wst_we) begin
      wst_mem[wst_addr] <= wst_wdata;
    end
    if (ctrl.wst_re) begin
      wst_rd_r <= wst_mem[wst_addr];
    end
  end

  // metadata never written reads as an empty queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_vld_r <= '0;
      rd_vld_r   <= 1'b0;
    end else begin
      if (ctrl.meta_we) begin
        meta_vld_r[sem_addr] <= 1'b1;
      end
      if (ctrl.rd_en) begin
        rd_vld_r <= meta_vld_r[sem_addr];
      end
    end
  end

  assign cnt_rd  = cnt_rd_r;
  assign meta_rd = rd_vld_r ? meta_q_r : '0;
  assign wst_rd  = wst_rd_r;

endmodule
